[rtl/pcsi_pkg.sv]
// shared types, constants and helpers for the palette collector
package pcsi_pkg;

  localparam int IDX_W          = 4;
  localparam int MAX_SLOTS      = 2 ** IDX_W;
  localparam int CNT_W          = IDX_W + 1;
  localparam int COLOUR_W       = 8;
  localparam int RGB_W          = 3 * COLOUR_W;
  localparam int CMD_W          = 2;
  localparam int ENTRIES_DEFAULT = 16;

  localparam logic [CMD_W-1:0] CMD_PIXEL = 2'd0;
  localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // commands from the controller to the datapath
  typedef struct packed {
    logic             pixel;
    logic             eoi;
    logic             read;
    logic             sort;
    logic             parity;
    logic             emit;
    logic             emit_last;
    logic [IDX_W-1:0] emit_idx;
  } pcsi_cmd_t;

  // status from the datapath back to the controller
  typedef struct packed {
    logic             grown;
    logic [CNT_W-1:0] count;
  } pcsi_status_t;

  // grey fallback: index * 17 is the index nibble repeated
  function automatic logic [COLOUR_W-1:0] grey_level(input logic [IDX_W-1:0] idx);
    return {idx, idx};
  endfunction

endpackage

[rtl/pcsi_ctrl.sv]
// controller: request decode, sort pass sequencing and index-map emission
module pcsi_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pcsi_pkg::CMD_W-1:0] cmd_code,
  input  pcsi_pkg::pcsi_status_t    status,
  output logic                      busy,
  output pcsi_pkg::pcsi_cmd_t       dp_cmd
);
  import pcsi_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] step;
  logic [IDX_W-1:0] step_next;
  logic             accept;
  logic             at_end;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  // step has reached the final entry (count - 1)
  assign at_end = ({1'b0, step} == (status.count - CNT_W'(1)));

  always_comb begin
    dp_cmd           = '0;
    dp_cmd.pixel     = accept && (cmd_code == CMD_PIXEL);
    dp_cmd.eoi       = accept && (cmd_code == CMD_END);
    dp_cmd.read      = accept && (cmd_code == CMD_READ);
    dp_cmd.sort      = (state == ST_SORT);
    dp_cmd.parity    = step[0];
    dp_cmd.emit      = (state == ST_EMIT);
    dp_cmd.emit_last = (state == ST_EMIT) && at_end;
    dp_cmd.emit_idx  = step;
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd_code == CMD_END) && status.grown) begin
          state_next = ST_SORT;
          step_next  = '0;
        end
      end
      ST_SORT: begin
        // count passes of odd-even transposition cover the count-1 tail entries
        if (at_end) begin
          state_next = ST_EMIT;
          step_next  = '0;
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (at_end) begin
          state_next = ST_IDLE;
        end else begin
          step_next = step + IDX_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

[rtl/pcsi_datapath.sv]
// datapath: palette registers, parallel match, compare-swap sorter, result register
module pcsi_datapath #(
  parameter int ENTRIES = pcsi_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pcsi_pkg::pcsi_cmd_t           dp_cmd,
  input  logic [pcsi_pkg::COLOUR_W-1:0] red,
  input  logic [pcsi_pkg::COLOUR_W-1:0] green,
  input  logic [pcsi_pkg::COLOUR_W-1:0] blue,
  input  logic [pcsi_pkg::IDX_W-1:0]    entry_index,
  output pcsi_pkg::pcsi_status_t        status,
  output logic                          valid,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_red,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_green,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_blue,
  output logic [pcsi_pkg::IDX_W-1:0]    out_index,
  output logic                          last
);
  import pcsi_pkg::*;

  localparam int CAP = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
  localparam int AW  = $clog2(CAP);

  logic [RGB_W-1:0] store      [CAP];
  logic [RGB_W-1:0] store_next [CAP];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             grown;
  logic             grown_next;
  logic [RGB_W-1:0] pix_rgb;
  logic             hit;
  logic [IDX_W-1:0] rd_addr;
  logic             rd_used;
  logic [RGB_W-1:0] rd_rgb;
  logic [COLOUR_W-1:0] grey;

  assign pix_rgb = {red, green, blue};
  assign status.grown = grown;
  assign status.count = count;

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < CAP; i++) begin
      if ((CNT_W'(i) < count) && (store[i] == pix_rgb)) begin
        hit = 1'b1;
      end
    end
  end

  always_comb begin
    store_next = store;
    count_next = count;
    grown_next = grown;
    if (dp_cmd.pixel && !hit && (count < CNT_W'(CAP))) begin
      store_next[count[AW-1:0]] = pix_rgb;
      count_next = count + CNT_W'(1);
      grown_next = 1'b1;
    end
    if (dp_cmd.eoi) begin
      grown_next = 1'b0;
    end
    if (dp_cmd.sort) begin
      // entry 0 stays put; disjoint pairs of one parity swap when out of order
      for (int j = 1; j < CAP - 1; j++) begin
        if (((j & 1) == int'(dp_cmd.parity)) && (CNT_W'(j + 1) < count) &&
            (store[j] > store[j + 1])) begin
          store_next[j]     = store[j + 1];
          store_next[j + 1] = store[j];
        end
      end
    end
  end

  assign rd_addr = dp_cmd.emit ? dp_cmd.emit_idx : entry_index;
  assign rd_used = ({1'b0, rd_addr} < count);
  assign rd_rgb  = store[rd_addr[AW-1:0]];
  assign grey    = grey_level(rd_addr);

  always_ff @(posedge clk) begin
    store <= store_next;
    if (dp_cmd.emit || dp_cmd.read) begin
      if (rd_used) begin
        out_red   <= rd_rgb[RGB_W-1 -: COLOUR_W];
        out_green <= rd_rgb[COLOUR_W +: COLOUR_W];
        out_blue  <= rd_rgb[COLOUR_W-1:0];
      end else begin
        out_red   <= grey;
        out_green <= grey;
        out_blue  <= grey;
      end
      out_index <= rd_addr;
      last      <= dp_cmd.read || dp_cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      grown <= 1'b0;
      valid <= 1'b0;
    end else begin
      count <= count_next;
      grown <= grown_next;
      valid <= dp_cmd.emit || dp_cmd.read;
    end
  end

endmodule

[rtl/palette_collect_sort_index_top.sv]
// top level of the palette collector with sorted index map
// Pixel (cmd 0) and read (cmd 2) requests are taken one per cycle with busy low; a pixel gives
// no result, a read gives one result in the cycle after it is taken. An end-of-image request
// (cmd 1) after the palette grew raises busy for count passes of the
// compare-swap sorter over the palette registers, then one result per entry on consecutive
// cycles with last on the final one. The receiver cannot stall: each result is shown on the
// result ports for exactly one cycle, marked by valid. No clearing pass after reset.
module palette_collect_sort_index_top #(
  parameter int ENTRIES = pcsi_pkg::ENTRIES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [pcsi_pkg::CMD_W-1:0]    cmd,
  input  logic [pcsi_pkg::COLOUR_W-1:0] red,
  input  logic [pcsi_pkg::COLOUR_W-1:0] green,
  input  logic [pcsi_pkg::COLOUR_W-1:0] blue,
  input  logic [pcsi_pkg::IDX_W-1:0]    entry_index,
  output logic                          valid,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_red,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_green,
  output logic [pcsi_pkg::COLOUR_W-1:0] out_blue,
  output logic [pcsi_pkg::IDX_W-1:0]    out_index,
  output logic                          last
);
  import pcsi_pkg::*;

  localparam int CAP = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;

  pcsi_cmd_t    dp_cmd;
  pcsi_status_t status;

  pcsi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd_code (cmd),
    .status   (status),
    .busy     (busy),
    .dp_cmd   (dp_cmd)
  );

  pcsi_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .dp_cmd      (dp_cmd),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .entry_index (entry_index),
    .status      (status),
    .valid       (valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_index   (out_index),
    .last        (last)
  );

`ifndef SYNTHESIS
  // palette never fills past its capacity
  assert property (@(posedge clk) disable iff (rst)
    status.count <= CNT_W'(CAP))
    else $error("palette count beyond capacity");

  // busy only rises after an end-of-image request was taken
  assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && !busy && (cmd == CMD_END)))
    else $error("busy rose without an end-of-image request");

  // the final emission shows up next cycle as a result marked last
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.emit_last |=> (valid && last))
    else $error("final index-map result missing or not marked last");

  // sorting only happens while busy and never with a read or pixel request
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.sort |-> (busy && !dp_cmd.read && !dp_cmd.pixel))
    else $error("sort step outside a busy period");
`endif

endmodule
